// ----- src/assert_macros.svh -----
// Assertion helpers shared by the blit engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

// ----- src/akcb_pkg.sv -----
package akcb_pkg;

    localparam int DIM_W           = 13;
    localparam int ADDR_W          = 26;
    localparam int PIXEL_W         = 32;
    localparam int MAX_DIM_DEFAULT = 4096;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int BPP_SHIFT       = $clog2(BYTES_PER_PIXEL);
    localparam int ALPHA_LSB       = 24;
    localparam int ALPHA_W         = 8;
    localparam int CFG_INDEX_W     = 3;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [ALPHA_W-1:0] ALPHA_CLEAR = 8'h00;

    localparam logic [DIM_W-1:0] DEST_WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0] DEST_HEIGHT_RESET = 13'd480;
    localparam logic [DIM_W-1:0] SRC_WIDTH_RESET   = 13'd64;
    localparam logic [DIM_W-1:0] SRC_HEIGHT_RESET  = 13'd64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEST_WIDTH  = 3'd0,
        CFG_DEST_HEIGHT = 3'd1,
        CFG_SRC_WIDTH   = 3'd2,
        CFG_SRC_HEIGHT  = 3'd3,
        CFG_OFFSET_X    = 3'd4,
        CFG_OFFSET_Y    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [DIM_W-1:0]       value;
    } cfg_write_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               image_start;
    } in_item_t;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [PIXEL_W-1:0] write_pixel;
        logic               image_end;
    } out_item_t;

    // Effective geometry: dimensions are already clamped to their legal range.
    typedef struct packed {
        logic [DIM_W-1:0]        dest_width;
        logic [DIM_W-1:0]        dest_height;
        logic [DIM_W-1:0]        src_width;
        logic [DIM_W-1:0]        src_height;
        logic signed [DIM_W-1:0] offset_x;
        logic signed [DIM_W-1:0] offset_y;
    } blit_cfg_t;

    // A classified pixel on its way from the front end to the address unit.
    typedef struct packed {
        logic               we;
        logic               last;
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
        logic [PIXEL_W-1:0] pixel;
    } queue_item_t;

endpackage

// ----- src/akcb_stream_if.sv -----
interface akcb_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

// ----- src/akcb_cfg.sv -----
module akcb_cfg #(
    parameter int MAX_DIM = akcb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    akcb_stream_if.sink           cfg,
    output akcb_pkg::blit_cfg_t   settings
);
    import akcb_pkg::*;

    blit_cfg_t cfg_reg;
    blit_cfg_t cfg_next;

    // A zero dimension behaves as one, anything above the limit as the limit.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end
        else begin
            r = v;
        end
        return r;
    endfunction

    assign cfg.ready = 1'b1;
    assign settings  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.payload.index)
                CFG_DEST_WIDTH:  cfg_next.dest_width  = eff_dim(cfg.payload.value);
                CFG_DEST_HEIGHT: cfg_next.dest_height = eff_dim(cfg.payload.value);
                CFG_SRC_WIDTH:   cfg_next.src_width   = eff_dim(cfg.payload.value);
                CFG_SRC_HEIGHT:  cfg_next.src_height  = eff_dim(cfg.payload.value);
                CFG_OFFSET_X:    cfg_next.offset_x    = signed'(cfg.payload.value);
                CFG_OFFSET_Y:    cfg_next.offset_y    = signed'(cfg.payload.value);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_width  <= eff_dim(DEST_WIDTH_RESET);
            cfg_reg.dest_height <= eff_dim(DEST_HEIGHT_RESET);
            cfg_reg.src_width   <= eff_dim(SRC_WIDTH_RESET);
            cfg_reg.src_height  <= eff_dim(SRC_HEIGHT_RESET);
            cfg_reg.offset_x    <= '0;
            cfg_reg.offset_y    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- src/akcb_front.sv -----
`include "assert_macros.svh"

module akcb_front #(
    parameter int MAX_DIM = akcb_pkg::MAX_DIM_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  akcb_pkg::blit_cfg_t settings,
    akcb_stream_if.sink         src,
    akcb_stream_if.source       q
);
    import akcb_pkg::*;

    localparam int CW    = $clog2(MAX_DIM);
    localparam int CMP_W = ((CW > DIM_W) ? CW : DIM_W) + 1;
    localparam int POS_W = CMP_W + 1;

    logic [CW-1:0]           col_reg;
    logic [CW-1:0]           col_next;
    logic [CW-1:0]           row_reg;
    logic [CW-1:0]           row_next;
    logic [CW-1:0]           col_cur;
    logic [CW-1:0]           row_cur;
    logic [CMP_W-1:0]        col_inc;
    logic [CMP_W-1:0]        row_inc;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic                    in_frame;
    logic                    alpha_set;
    logic                    last;
    logic                    take;

    assign take = src.valid && src.ready;

    always_comb
    begin
        // A start-of-image pixel is placed as if both counters were already zero.
        col_cur = src.payload.image_start ? '0 : col_reg;
        row_cur = src.payload.image_start ? '0 : row_reg;

        dx = POS_W'(settings.offset_x) + signed'(POS_W'(col_cur));
        dy = POS_W'(settings.offset_y) + signed'(POS_W'(row_cur));

        in_frame = !dx[POS_W-1] && !dy[POS_W-1]
                && (dx < signed'(POS_W'(settings.dest_width)))
                && (dy < signed'(POS_W'(settings.dest_height)));
        alpha_set = src.payload.pixel[ALPHA_LSB +: ALPHA_W] != ALPHA_CLEAR;

        last = (CMP_W'(col_cur) == CMP_W'(settings.src_width) - CMP_W'(1))
            && (CMP_W'(row_cur) == CMP_W'(settings.src_height) - CMP_W'(1));

        col_inc  = CMP_W'(col_cur) + CMP_W'(1);
        row_inc  = CMP_W'(row_cur) + CMP_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (col_inc >= CMP_W'(settings.src_width))
            begin
                col_next = '0;
                row_next = (row_inc >= CMP_W'(settings.src_height)) ? '0 : CW'(row_inc);
            end
            else
            begin
                col_next = CW'(col_inc);
                row_next = row_cur;
            end
        end
    end

    assign src.ready       = q.ready;
    assign q.valid         = src.valid;
    assign q.payload.we    = in_frame && alpha_set;
    assign q.payload.last  = last;
    assign q.payload.x     = DIM_W'(dx);
    assign q.payload.y     = DIM_W'(dy);
    assign q.payload.pixel = src.payload.pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    `ASSERT_ALWAYS(a_col_in_range, clk, rst_n, CMP_W'(col_reg) < CMP_W'(MAX_DIM))
    `ASSERT_ALWAYS(a_row_in_range, clk, rst_n, CMP_W'(row_reg) < CMP_W'(MAX_DIM))

endmodule

// ----- src/akcb_queue.sv -----
`include "assert_macros.svh"

module akcb_queue (
    input  logic          clk,
    input  logic          rst_n,
    akcb_stream_if.sink   wr,
    akcb_stream_if.source rd
);
    import akcb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t      mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;
    logic             empty_or_full;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign wr.ready   = count_reg != CNT_W'(QUEUE_DEPTH);
    assign rd.valid   = count_reg != '0;
    assign rd.payload = mem[rd_ptr_reg];
    assign push       = wr.valid && wr.ready;
    assign pop        = rd.valid && rd.ready;

    assign empty_or_full = (count_reg == '0) || (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr.payload;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_ptr_match, clk, rst_n, empty_or_full, wr_ptr_reg == rd_ptr_reg)

endmodule

// ----- src/akcb_back.sv -----
`include "assert_macros.svh"

module akcb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [akcb_pkg::DIM_W-1:0] dest_width,
    akcb_stream_if.sink            q,
    akcb_stream_if.source          dst
);
    import akcb_pkg::*;

    localparam int PROD_W = 2 * DIM_W;

    logic              s1_valid_reg;
    queue_item_t       s1_item_reg;
    logic [PROD_W-1:0] s1_row_base_reg;
    logic              out_valid_reg;
    out_item_t         out_item_reg;
    out_item_t         out_next;
    logic              out_adv;
    logic              s1_adv;
    logic [ADDR_W-1:0] pixel_index;
    logic              out_skip;
    logic              out_fields_zero;

    // The row base is registered so the multiply and the final add sit in
    // separate stages.
    assign out_adv = !out_valid_reg || dst.ready;
    assign s1_adv  = !s1_valid_reg || out_adv;
    assign q.ready = s1_adv;

    always_comb
    begin
        pixel_index = ADDR_W'(s1_row_base_reg + PROD_W'(s1_item_reg.x));
        out_next.write_enable  = s1_item_reg.we;
        out_next.write_address = s1_item_reg.we ? (pixel_index << BPP_SHIFT) : '0;
        out_next.write_pixel   = s1_item_reg.we ? s1_item_reg.pixel : '0;
        out_next.image_end     = s1_item_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= q.valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && q.valid)
        begin
            s1_item_reg     <= q.payload;
            s1_row_base_reg <= PROD_W'(q.payload.y) * PROD_W'(dest_width);
        end
        if (out_adv && s1_valid_reg)
        begin
            out_item_reg <= out_next;
        end
    end

    assign dst.valid   = out_valid_reg;
    assign dst.payload = out_item_reg;

    assign out_skip        = out_valid_reg && !out_item_reg.write_enable;
    assign out_fields_zero = (out_item_reg.write_address == '0)
                          && (out_item_reg.write_pixel == '0);

    `ASSERT_IMPLIES(a_nowrite_zero, clk, rst_n, out_skip, out_fields_zero)

endmodule

// ----- src/alpha_keyed_clipped_blit.sv -----
// Path: an input pixel enters the queue, then the row-base register of the address unit,
// then its output register, from which the result is presented on dst.
// Throughput: one pixel per cycle while dst accepts, set by the column/row counter update
// in the front end; a four-entry queue decouples it from the two-stage address unit.
// Reset (rst_n low, asynchronous) clears the counters, the queue and all valid flags,
// and loads the geometry registers with 640x480 destination, 64x64 source, offset 0.
module alpha_keyed_clipped_blit #(
    parameter int MAX_DIM = akcb_pkg::MAX_DIM_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    akcb_stream_if.sink   cfg,
    akcb_stream_if.sink   src,
    akcb_stream_if.source dst
);
    import akcb_pkg::*;

    blit_cfg_t settings;

    akcb_stream_if #(.payload_t(queue_item_t)) front_q ();
    akcb_stream_if #(.payload_t(queue_item_t)) back_q ();

    akcb_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    akcb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .settings (settings),
        .src      (src),
        .q        (front_q)
    );

    akcb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (front_q),
        .rd    (back_q)
    );

    akcb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .dest_width (settings.dest_width),
        .q          (back_q),
        .dst        (dst)
    );

endmodule
